FILE: hw/rtl/rpn_expression_evaluator_core_assert.svh
// ---------------------------------------------------------------------------
// rpn_expression_evaluator_core_assert.svh
// Assertion macros for the evaluator RTL.
// ---------------------------------------------------------------------------
`ifndef RPN_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define RPN_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RPN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rpn_pkg.sv
// ---------------------------------------------------------------------------
// rpn_pkg
// Types and constants shared by the postfix expression evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    localparam int DATA_W            = 32;
    localparam int CNT_W             = $clog2(DATA_W);
    localparam int DEF_STACK_DEPTH   = 128;

    // ASCII codes the decoder recognizes
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CALC,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/rpn_alu.sv
// ---------------------------------------------------------------------------
// rpn_alu
// Shared arithmetic unit: add, subtract and multiply without iteration, signed
// division truncating toward zero by a one-bit-per-cycle shift-subtract loop.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_alu
    import rpn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [DATA_W-1:0] i_lhs,
    input  wire logic [DATA_W-1:0] i_rhs,
    output logic                   o_done,
    output logic                   o_busy,
    output logic [DATA_W-1:0]      o_result
);

    logic              r_busy,   n_busy;
    logic              r_done,   n_done;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [DATA_W-1:0] r_rem,    n_rem;
    logic [DATA_W-1:0] r_quo,    n_quo;
    logic [DATA_W-1:0] r_dvs,    n_dvs;
    logic              r_neg,    n_neg;
    logic [DATA_W-1:0] r_result, n_result;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] quo_step;
    logic [DATA_W-1:0] rem_step;

    // One restoring division step on magnitudes
    always_comb begin
        shifted  = {r_rem, r_quo[DATA_W-1]};
        diff     = shifted - {1'b0, r_dvs};
        quo_step = {r_quo[DATA_W-2:0], ~diff[DATA_W]};
        rem_step = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
    end

    // Operation start and iteration control
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_count  = r_count;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_neg    = r_neg;
        n_result = r_result;
        if (i_req.start) begin
            case (i_req.op)
                OP_ADD: begin
                    n_result = i_lhs + i_rhs;
                    n_done   = 1'b1;
                end
                OP_SUB: begin
                    n_result = i_lhs - i_rhs;
                    n_done   = 1'b1;
                end
                OP_MUL: begin
                    n_result = i_lhs * i_rhs;
                    n_done   = 1'b1;
                end
                OP_DIV: begin
                    n_neg   = i_lhs[DATA_W-1] ^ i_rhs[DATA_W-1];
                    n_quo   = i_lhs[DATA_W-1] ? (~i_lhs + 1'b1) : i_lhs;
                    n_dvs   = i_rhs[DATA_W-1] ? (~i_rhs + 1'b1) : i_rhs;
                    n_rem   = '0;
                    n_count = '1;
                    n_busy  = 1'b1;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            n_rem   = rem_step;
            n_quo   = quo_step;
            n_count = r_count - 1'b1;
            if (r_count == '0) begin
                n_busy   = 1'b0;
                n_done   = 1'b1;
                n_result = r_neg ? (~quo_step + 1'b1) : quo_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_count  <= n_count;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvs    <= n_dvs;
        r_neg    <= n_neg;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_busy   = r_busy;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_stack.sv
// ---------------------------------------------------------------------------
// rpn_stack
// Operand storage below the top of stack: one write port, one registered
// read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_stack
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    localparam int AW         = $clog2(STACK_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0]      o_rd_data
);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_expression_evaluator_core.sv
// ---------------------------------------------------------------------------
// rpn_expression_evaluator_core
// Single-digit postfix calculator: one ASCII character per input transfer,
// one result transfer (value, status) after the character marked tlast.
// ---------------------------------------------------------------------------
// The block takes one character at a time and is not ready again until that
// character is done. A digit or an ignored character goes through decode and
// finish; + - * add one stack read and one pass through the arithmetic unit;
// / waits on the 32-step shift-subtract loop of the shared
// arithmetic unit. A character marked tlast also waits, before the next one
// is taken, until the previous result has left the output register. The top
// of stack lives in a register and the rest in a memory of STACK_DEPTH words
// that needs no clearing after reset. Status: 0 ok, 1 operand underflow (or
// empty stack at the end), 2 stack overflow, 3 divide by zero; value is 0
// whenever status is not 0. An error holds until the end of the expression.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_expression_evaluator_core
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

    `include "rpn_expression_evaluator_core_assert.svh"

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    t_state            r_state,    n_state;
    logic [7:0]        r_char,     n_char;
    logic              r_last,     n_last;
    logic [SPW-1:0]    r_sp,       n_sp;
    t_status           r_err,      n_err;
    logic [DATA_W-1:0] r_tos,      n_tos;
    t_op               r_op,       n_op;
    logic              r_m_valid,  n_m_valid;
    logic [DATA_W-1:0] r_m_value,  n_m_value;
    t_status           r_m_status, n_m_status;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    t_alu_req          alu_req;
    logic              alu_done;
    logic              alu_busy;
    logic [DATA_W-1:0] alu_result;

    rpn_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (r_tos),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_lhs    (mem_rd_data),
        .i_rhs    (r_tos),
        .o_done   (alu_done),
        .o_busy   (alu_busy),
        .o_result (alu_result)
    );

    // Sequencer: next state, stack control and output register
    always_comb begin
        logic is_op;
        t_op  dec_op;

        n_state    = r_state;
        n_char     = r_char;
        n_last     = r_last;
        n_sp       = r_sp;
        n_err      = r_err;
        n_tos      = r_tos;
        n_op       = r_op;
        n_m_valid  = r_m_valid;
        n_m_value  = r_m_value;
        n_m_status = r_m_status;
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(r_sp - SPW'(1));
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(r_sp - SPW'(2));
        alu_req.start = 1'b0;
        alu_req.op    = r_op;

        is_op  = 1'b1;
        case (r_char)
            CHAR_PLUS:  dec_op = OP_ADD;
            CHAR_MINUS: dec_op = OP_SUB;
            CHAR_STAR:  dec_op = OP_MUL;
            CHAR_SLASH: dec_op = OP_DIV;
            default: begin
                dec_op = OP_ADD;
                is_op  = 1'b0;
            end
        endcase

        // result register drains independently of the sequencer
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_char  = s_axis_tdata;
                    n_last  = s_axis_tlast;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                if (r_err != ST_OK) begin
                    // sticky error: character ignored
                end else if (r_char inside {[CHAR_0:CHAR_9]}) begin
                    if (r_sp >= SPW'(STACK_DEPTH)) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        // old top moves into the memory
                        mem_wr_en = (r_sp != '0);
                        n_tos     = DATA_W'(r_char - CHAR_0);
                        n_sp      = r_sp + 1'b1;
                    end
                end else if (is_op) begin
                    if (r_sp < SPW'(2)) begin
                        n_err = ST_UNDERFLOW;
                    end else if (dec_op == OP_DIV && r_tos == '0) begin
                        n_err = ST_DIVZERO;
                    end else begin
                        mem_rd_en = 1'b1;
                        n_op      = dec_op;
                        n_state   = S_READ;
                    end
                end
            end
            S_READ: begin
                alu_req.start = 1'b1;
                n_state       = S_CALC;
            end
            S_CALC: begin
                if (alu_done) begin
                    n_tos   = alu_result;
                    n_sp    = r_sp - 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_m_value  = '0;
                        n_m_status = r_err;
                    end else if (r_sp == '0) begin
                        n_m_value  = '0;
                        n_m_status = ST_UNDERFLOW;
                    end else begin
                        n_m_value  = r_tos;
                        n_m_status = ST_OK;
                    end
                    n_sp    = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_err     <= ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_err     <= n_err;
            r_m_valid <= n_m_valid;
        end
        r_char     <= n_char;
        r_last     <= n_last;
        r_tos      <= n_tos;
        r_op       <= n_op;
        r_m_value  <= n_m_value;
        r_m_status <= n_m_status;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_status, r_m_value};

    // Checks on sequencer and arithmetic unit interplay
    `RPN_ASSERT_NOW(a_idle_alu_quiet, i_clk, i_rst_n, r_state == S_IDLE, !alu_busy && !alu_done, "arithmetic unit active while idle")
    `RPN_ASSERT_NOW(a_done_in_calc, i_clk, i_rst_n, alu_done, r_state == S_CALC, "arithmetic result outside calc state")
    `RPN_ASSERT_NEXT(a_err_skips_op, i_clk, i_rst_n, r_state == S_DECODE && r_err != ST_OK, r_state == S_FINISH && r_err == $past(r_err), "error not sticky")
    `RPN_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, r_state == S_FINISH && r_last && (!r_m_valid || m_axis_tready), r_sp == '0 && r_err == ST_OK && m_axis_tvalid, "end of expression did not clear stack")

endmodule

`default_nettype wire

FILE: test/rpn_expression_evaluator_checker.sv
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_checker
// Watches both stream channels of the postfix evaluator. Every accepted
// character runs through a local model of the operand stack; each character
// marked tlast queues the expected (value, status). Accepted results are
// compared in order against that queue, and mismatches are counted.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator_checker
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_char,          // [7:0] char_code
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,         // [31:0] value, [33:32] status, [39:34] zero
    output int          o_fail_count,
    output int          o_results_due,
    output int          o_results_checked,
    output logic [3:0]  o_status_seen       // one bit per status code
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } t_result;

    // Local copy of the evaluator state
    logic [31:0] operand_mem [STACK_DEPTH];
    int unsigned operand_count;
    t_status     sticky_err;

    t_result     results_due [$];

    // Signed division that truncates toward zero, wrapping on overflow
    function automatic logic [31:0] trunc_quotient(logic [31:0] num, logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] quo;
        mag_n = num[31] ? -num : num;
        mag_d = den[31] ? -den : den;
        quo   = mag_n / mag_d;
        return (num[31] ^ den[31]) ? -quo : quo;
    endfunction

    // Apply one character to the stack; queue a result on the final one
    task automatic eval_char(input logic [7:0] ch, input logic fin);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        logic        is_digit;
        logic        is_op;
        t_result     outcome;
        is_digit = (ch >= CHAR_0) && (ch <= CHAR_9);
        is_op    = (ch == CHAR_PLUS) || (ch == CHAR_MINUS) ||
                   (ch == CHAR_STAR) || (ch == CHAR_SLASH);
        res      = '0;
        if (sticky_err == ST_OK && is_digit) begin
            if (operand_count >= STACK_DEPTH) begin
                sticky_err = ST_OVERFLOW;
            end else begin
                operand_mem[operand_count] = ch - CHAR_0;
                operand_count++;
            end
        end else if (sticky_err == ST_OK && is_op) begin
            if (operand_count < 2) begin
                sticky_err = ST_UNDERFLOW;
            end else begin
                rhs = operand_mem[operand_count - 1];
                lhs = operand_mem[operand_count - 2];
                case (ch)
                    CHAR_PLUS:  res = lhs + rhs;
                    CHAR_MINUS: res = lhs - rhs;
                    CHAR_STAR:  res = lhs * rhs;
                    default: begin
                        if (rhs == '0) sticky_err = ST_DIVZERO;
                        else           res = trunc_quotient(lhs, rhs);
                    end
                endcase
                if (sticky_err == ST_OK) begin
                    operand_count--;
                    operand_mem[operand_count - 1] = res;
                end
            end
        end

        if (fin) begin
            if (sticky_err != ST_OK) begin
                outcome.status = sticky_err;
                outcome.value  = '0;
            end else if (operand_count == 0) begin
                outcome.status = ST_UNDERFLOW;
                outcome.value  = '0;
            end else begin
                outcome.status = ST_OK;
                outcome.value  = operand_mem[operand_count - 1];
            end
            results_due.push_back(outcome);
            operand_count = 0;
            sticky_err    = ST_OK;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            operand_count = 0;
            sticky_err    = ST_OK;
            results_due.delete();
            o_fail_count      = 0;
            o_results_checked = 0;
            o_status_seen     = '0;
        end else begin
            if (i_in_valid && i_in_ready)
                eval_char(i_in_char, i_in_last);

            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result: value %0d status %0d", $time,
                             $signed(i_out_data[31:0]), i_out_data[33:32]);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    o_results_checked++;
                    o_status_seen[want.status] = 1'b1;
                    if (i_out_data[31:0] !== want.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                                 want.value, $signed(i_out_data[31:0]));
                        o_fail_count++;
                    end
                    if (i_out_data[33:32] !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                                 want.status, i_out_data[33:32]);
                        o_fail_count++;
                    end
                    if (i_out_data[39:34] !== '0) begin
                        $display("%0t: padding mismatch: expected 0, actual %0h", $time,
                                 i_out_data[39:34]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_results_due = results_due.size();
    end

endmodule

FILE: test/rpn_expression_evaluator_core_test.sv
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_core_test
// Drives postfix expressions into the evaluator one character per transfer:
// a short directed set, full-stack, overflow and min-int cases, then random
// expressions (mostly well formed, some broken or noisy) with random idling
// on both channels and one long output stall. The checker does the scoring.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator_core_test
    import rpn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 700;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] char_code
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;      // [31:0] value, [33:32] status, [39:34] zero

    int          fail_count;
    int          results_due;
    int          results_checked;
    logic [3:0]  status_seen;

    int          chars_sent;
    int          exprs_sent;
    int          stall_cycles;
    logic        steady;
    logic        hold_req;
    logic        hold_done;

    rpn_expression_evaluator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rpn_expression_evaluator_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (s_axis_tvalid),
        .i_in_ready        (s_axis_tready),
        .i_in_char         (s_axis_tdata),
        .i_in_last         (s_axis_tlast),
        .i_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .i_out_data        (m_axis_tdata),
        .o_fail_count      (fail_count),
        .o_results_due     (results_due),
        .o_results_checked (results_checked),
        .o_status_seen     (status_seen)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] op_char(t_op op);
        case (op)
            OP_ADD:  return CHAR_PLUS;
            OP_SUB:  return CHAR_MINUS;
            OP_MUL:  return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    // One input transfer; called and returning at a falling edge
    task automatic offer(input logic [7:0] ch, input logic fin);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tlast  = fin;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
        if (fin) exprs_sent++;
        @(negedge i_clk);
    endtask

    // A whole string, tlast on the final character when close is set
    task automatic send_text(input string txt, input logic close);
        for (int k = 0; k < txt.len(); k++)
            offer(txt.getc(k), close && (k == txt.len() - 1));
    endtask

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int          n_ops;
        int          pushes;
        int          ops_left;
        int          depth;
        int          len;
        logic        trail;
        logic [7:0]  ch;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        chars_sent    = 0;
        exprs_sent    = 0;
        stall_cycles  = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: all operators, extreme bytes ignored mid-expression
        send_text("94-", 1'b0);
        offer(8'h00, 1'b0);
        send_text("7*", 1'b0);
        offer(8'hFF, 1'b0);
        send_text("3/", 1'b1);
        // negative quotient truncates toward zero
        send_text("07-2/", 1'b1);
        // divide by zero, then sticky error swallows the rest
        send_text("50/3", 1'b1);
        // operator without operands
        send_text("+", 1'b1);
        // nothing on the stack at the end
        send_text("a", 1'b1);
        // leftover operands: only the top is reported
        send_text("12", 1'b1);

        // Stack limits: exactly full, then four pushes too many
        for (int k = 0; k < DEF_STACK_DEPTH; k++)
            offer(CHAR_0 + 8'($urandom_range(9)), k == DEF_STACK_DEPTH - 1);
        for (int k = 0; k < DEF_STACK_DEPTH + 4; k++)
            offer(CHAR_0 + 8'($urandom_range(9)), k == DEF_STACK_DEPTH + 3);
        // 2^31 wraps to the most negative value, then divide by -1
        send_text("88888888882**********01-/", 1'b1);

        // Random expressions
        for (int e = 0; chars_sent < ITEM_TARGET; e++) begin
            if (e == 20) hold_req = 1'b1;
            steady = (e >= 25) && (e < 40);
            if ($urandom_range(99) < 80) begin
                // well formed, with occasional noise and leftover operands
                n_ops    = $urandom_range(0, 7);
                pushes   = n_ops + 1 + (($urandom_range(99) < 20) ? $urandom_range(1, 2) : 0);
                ops_left = n_ops;
                depth    = 0;
                trail    = ($urandom_range(99) < 10);
                while (pushes + ops_left > 0) begin
                    if ($urandom_range(99) < 8)
                        offer(8'($urandom_range(255)), 1'b0);
                    if (depth >= 2 && ops_left > 0 && (pushes == 0 || $urandom_range(1))) begin
                        ch = op_char(t_op'($urandom_range(3)));
                        depth--;
                        ops_left--;
                    end else begin
                        ch = CHAR_0 + 8'($urandom_range(9));
                        depth++;
                        pushes--;
                    end
                    offer(ch, (pushes + ops_left == 0) && !trail);
                end
                if (trail)
                    offer(8'($urandom_range(255)), 1'b1);
            end else begin
                // broken: random mix of digits, operators and any byte
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(4))
                        0, 1:    ch = CHAR_0 + 8'($urandom_range(9));
                        2, 3:    ch = op_char(t_op'($urandom_range(3)));
                        default: ch = 8'($urandom_range(255));
                    endcase
                    offer(ch, k == len - 1);
                end
            end
        end

        // Drain
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d characters in %0d expressions: all operators, stack full",
                 chars_sent, exprs_sent);
        $display("and overflow, min-int / -1, sticky errors; %0d results, statuses seen %b",
                 results_checked, status_seen);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
